>>> hdl/pgac_pkg.sv
// Shared constants and arithmetic helpers for the pixel-to-gray compositing unit.
`default_nettype none

package pgac_pkg;

   // Default palette depth
   localparam int PALETTE_ENTRIES_DEFAULT = 256;

   // Pixel format codes
   localparam logic [2:0] FMT_GRAY    = 3'd0;
   localparam logic [2:0] FMT_RGB     = 3'd1;
   localparam logic [2:0] FMT_INDEXED = 3'd2;
   localparam logic [2:0] FMT_GRAY_A  = 3'd3;
   localparam logic [2:0] FMT_RGBA    = 3'd4;

   // Configuration register indexes
   localparam logic [1:0] CSR_PIXEL_FORMAT  = 2'd0;
   localparam logic [1:0] CSR_SAMPLE_DEPTH  = 2'd1;
   localparam logic [1:0] CSR_PALETTE_VALID = 2'd2;
   localparam logic [1:0] CSR_PALETTE_ALPHA = 2'd3;

   // Effective sample depth codes
   localparam logic [1:0] DEP_1 = 2'd0;
   localparam logic [1:0] DEP_2 = 2'd1;
   localparam logic [1:0] DEP_4 = 2'd2;
   localparam logic [1:0] DEP_8 = 2'd3;

   localparam logic [7:0] GRAY_UNKNOWN = 8'd128;

   typedef struct packed {
      logic [23:0] rgb;
      logic [7:0]  alpha;
   } pal_entry_type;

   // Any depth other than 1, 2 or 4 behaves as 8.
   function automatic logic [1:0] depth_code(input logic [3:0] depth);
      logic [1:0] code;
      case (depth)
         4'd1:    code = DEP_1;
         4'd2:    code = DEP_2;
         4'd4:    code = DEP_4;
         default: code = DEP_8;
      endcase
      return code;
   endfunction

   // Samples held in one packed byte.
   function automatic logic [3:0] samples_per_byte(input logic [1:0] code);
      logic [3:0] per;
      case (code)
         DEP_1:   per = 4'd8;
         DEP_2:   per = 4'd4;
         DEP_4:   per = 4'd2;
         default: per = 4'd1;
      endcase
      return per;
   endfunction

   // Most significant sample of a packed byte, right aligned.
   function automatic logic [7:0] top_sample(input logic [7:0] packed_byte,
                                             input logic [1:0] code);
      logic [7:0] s;
      case (code)
         DEP_1:   s = {7'd0, packed_byte[7]};
         DEP_2:   s = {6'd0, packed_byte[7:6]};
         DEP_4:   s = {4'd0, packed_byte[7:4]};
         default: s = packed_byte;
      endcase
      return s;
   endfunction

   function automatic logic [7:0] shift_out(input logic [7:0] packed_byte,
                                            input logic [1:0] code);
      logic [7:0] b;
      case (code)
         DEP_1:   b = {packed_byte[6:0], 1'b0};
         DEP_2:   b = {packed_byte[5:0], 2'b0};
         DEP_4:   b = {packed_byte[3:0], 4'b0};
         default: b = 8'd0;
      endcase
      return b;
   endfunction

   // s*255/(2^depth-1) is exact bit replication for these depths.
   function automatic logic [7:0] widen(input logic [7:0] s, input logic [1:0] code);
      logic [7:0] g;
      case (code)
         DEP_1:   g = {8{s[0]}};
         DEP_2:   g = {4{s[1:0]}};
         DEP_4:   g = {2{s[3:0]}};
         default: g = s;
      endcase
      return g;
   endfunction

   // (77 R + 150 G + 29 B) >> 8; the sum stays below 2^16.
   function automatic logic [7:0] luma(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
      logic [15:0] sum;
      sum = 16'(r) * 16'd77 + 16'(g) * 16'd150 + 16'(b) * 16'd29;
      return sum[15:8];
   endfunction

   // (gray*a + 255*(255-a)) / 255. The division uses the identity
   // floor(x/255) = (x + (x >> 8) + 1) >> 8, exact for every x up to 255*255.
   function automatic logic [7:0] over_white(input logic [7:0] gray,
                                             input logic [7:0] a);
      logic [15:0] x;
      logic [16:0] q;
      x = 16'(gray) * 16'(a) + 16'(8'd255 - a) * 16'd255;
      q = 17'(x) + 17'(x[15:8]) + 17'd1;
      return q[15:8];
   endfunction

endpackage

`default_nettype wire

>>> hdl/pgac_palette_ram.sv
// Palette memory: one write port, one read port with registered read data.
`default_nettype none

module pgac_palette_ram #(
   parameter int ENTRIES = pgac_pkg::PALETTE_ENTRIES_DEFAULT,
   localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  wire                       clock,
   input  wire                       wr_en,
   input  wire  [ADDR_W-1:0]         wr_addr,
   input  wire  pgac_pkg::pal_entry_type wr_data,
   input  wire                       rd_en,
   input  wire  [ADDR_W-1:0]         rd_addr,
   output pgac_pkg::pal_entry_type   rd_data
);
   import pgac_pkg::*;

   pal_entry_type mem [ENTRIES];
   pal_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/pixel_to_gray_alpha_composite_unit.sv
// Top level of the pixel-to-gray converter with alpha compositing onto white.
//
//   Channel  Direction  Handshake           Payload
//   req_     in         tvalid/tready       tdata, tuser = func
//   rsp_     out        tvalid/tready       tdata = gray_level, tlast = run_end
//   csr_     in         we (no wait)        index, wdata
//
// Structure: the block is a four-register pipeline (unpacker, palette read, luma,
// blend into the result register), so a result passes from the unpacker through
// the palette read and luma registers into the result register. The unpacker
// takes no new input beat until the current one has issued all its samples:
// one for rgb, gray plus alpha, rgba and unknown formats, none for palette
// writes, and up to 8/depth for packed gray or index bytes.
// Reset is synchronous and active high; it clears the valid flags and the
// configuration registers but not the palette, whose contents are undefined
// until written. All stages advance together whenever the result register is
// empty or being taken, so a stall on rsp_tready backs up the whole pipe.
`default_nettype none

module pixel_to_gray_alpha_composite_unit #(
   parameter int PALETTE_ENTRIES = pgac_pkg::PALETTE_ENTRIES_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   // Input beats
   input  wire         req_tvalid,
   output logic        req_tready,
   // chan0 [7:0], chan1 [15:8], chan2 [23:16], chan3 [31:24],
   // palette_slot [39:32], sample_count [43:40], zero [47:44]
   input  wire  [47:0] req_tdata,
   // func [0]: 0 pixel data, 1 palette write
   input  wire  [0:0]  req_tuser,
   // Result beats
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // gray_level [7:0]
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   // Configuration writes
   input  wire         csr_we,
   input  wire  [1:0]  csr_index,
   input  wire  [3:0]  csr_wdata
);
   import pgac_pkg::*;

   localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam logic [8:0] ENTRY_LIMIT = 9'(PALETTE_ENTRIES);

   // Configuration registers.
   logic [2:0] fmt_ff;
   logic [3:0] depth_ff;
   logic       pal_valid_ff;
   logic       pal_alpha_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff          <= FMT_GRAY;
         depth_ff        <= 4'd8;
         pal_valid_ff    <= 1'b0;
         pal_alpha_en_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PIXEL_FORMAT:  fmt_ff          <= csr_wdata[2:0];
            CSR_SAMPLE_DEPTH:  depth_ff        <= csr_wdata;
            CSR_PALETTE_VALID: pal_valid_ff    <= csr_wdata[0];
            CSR_PALETTE_ALPHA: pal_alpha_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic [1:0] dep_code;
   logic       packed_fmt;
   assign dep_code   = depth_code(depth_ff);
   assign packed_fmt = (fmt_ff == FMT_GRAY) || (fmt_ff == FMT_INDEXED);

   // The whole pipe moves when the result register can take a new value.
   logic advance;
   assign advance = !rsp_tvalid || rsp_tready;

   // Stage A: holds the accepted beat and walks through its packed samples.
   logic       a_valid_ff, a_valid_in;
   logic       a_func_ff;
   logic [7:0] a_byte_ff, a_c1_ff, a_c2_ff, a_c3_ff, a_slot_ff;
   logic [2:0] a_rem_ff;
   logic       a_done;
   logic       accept;

   assign a_done     = !a_valid_ff || a_func_ff || (a_rem_ff == 3'd0);
   assign req_tready = advance && a_done;
   assign accept     = req_tvalid && req_tready;

   // Number of results for the beat being accepted; a_rem_ff holds it minus one.
   logic [3:0] in_cnt, per, cnt_lo, cnt_n;
   assign in_cnt = req_tdata[43:40];
   assign per    = samples_per_byte(dep_code);
   assign cnt_lo = (in_cnt == 4'd0) ? 4'd1 : in_cnt;
   assign cnt_n  = packed_fmt ? ((cnt_lo > per) ? per : cnt_lo) : 4'd1;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (advance) begin
         a_valid_in = accept || !a_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_func_ff <= req_tuser[0];
         a_byte_ff <= req_tdata[7:0];
         a_c1_ff   <= req_tdata[15:8];
         a_c2_ff   <= req_tdata[23:16];
         a_c3_ff   <= req_tdata[31:24];
         a_slot_ff <= req_tdata[39:32];
         a_rem_ff  <= 3'(cnt_n - 4'd1);
      end else if (advance && !a_done) begin
         a_byte_ff <= shift_out(a_byte_ff, dep_code);
         a_rem_ff  <= a_rem_ff - 3'd1;
      end
   end

   // Palette writes retire from stage A in order with the reads of earlier
   // pixel beats, so a later write never overtakes an earlier lookup.
   logic [7:0]    a_sample;
   logic          pal_wr_en, pal_rd_en;
   pal_entry_type pal_wr_data, pal_rd_data;

   // For formats that are not packed the sample is the whole first byte.
   assign a_sample    = packed_fmt ? top_sample(a_byte_ff, dep_code) : a_byte_ff;
   assign pal_wr_en   = advance && a_valid_ff && a_func_ff &&
                        ({1'b0, a_slot_ff} < ENTRY_LIMIT);
   assign pal_rd_en   = advance && a_valid_ff && !a_func_ff;
   assign pal_wr_data = '{rgb: {a_byte_ff, a_c1_ff, a_c2_ff}, alpha: a_c3_ff};

   pgac_palette_ram #(
      .ENTRIES (PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (a_slot_ff[IDX_W-1:0]),
      .wr_data (pal_wr_data),
      .rd_en   (pal_rd_en),
      .rd_addr (a_sample[IDX_W-1:0]),
      .rd_data (pal_rd_data)
   );

   // Stage B: sample and channel bytes, aligned with the palette read data.
   logic       b_valid_ff;
   logic       b_last_ff, b_oob_ff;
   logic [7:0] b_sample_ff, b_c0_ff, b_c1_ff, b_c2_ff, b_c3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff && !a_func_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_last_ff   <= a_rem_ff == 3'd0;
         b_oob_ff    <= {1'b0, a_sample} >= ENTRY_LIMIT;
         b_sample_ff <= a_sample;
         b_c0_ff     <= a_byte_ff;
         b_c1_ff     <= a_c1_ff;
         b_c2_ff     <= a_c2_ff;
         b_c3_ff     <= a_c3_ff;
      end
   end

   // Stage C: choose the gray source per format and reduce RGB to luma.
   // An index beyond the table reads as black with zero alpha.
   logic [23:0] pal_rgb;
   logic [7:0]  pal_alpha;
   logic [7:0]  r_sel, g_sel, b_sel;
   logic [7:0]  c_gray_in, c_alpha_in;
   logic        c_blend_in;

   assign pal_rgb   = b_oob_ff ? 24'd0 : pal_rd_data.rgb;
   assign pal_alpha = b_oob_ff ? 8'd0 : pal_rd_data.alpha;

   always_comb begin
      if (fmt_ff == FMT_INDEXED) begin
         r_sel = pal_rgb[23:16];
         g_sel = pal_rgb[15:8];
         b_sel = pal_rgb[7:0];
      end else begin
         r_sel = b_c0_ff;
         g_sel = b_c1_ff;
         b_sel = b_c2_ff;
      end
   end

   always_comb begin
      c_alpha_in = b_c3_ff;
      c_blend_in = 1'b0;
      case (fmt_ff)
         FMT_GRAY: begin
            c_gray_in = widen(b_sample_ff, dep_code);
         end
         FMT_RGB: begin
            c_gray_in = luma(r_sel, g_sel, b_sel);
         end
         FMT_INDEXED: begin
            if (pal_valid_ff) begin
               c_gray_in  = luma(r_sel, g_sel, b_sel);
               c_alpha_in = pal_alpha;
               c_blend_in = pal_alpha_en_ff;
            end else begin
               c_gray_in = widen(b_sample_ff, dep_code);
            end
         end
         FMT_GRAY_A: begin
            c_gray_in  = b_c0_ff;
            c_alpha_in = b_c1_ff;
            c_blend_in = 1'b1;
         end
         FMT_RGBA: begin
            c_gray_in  = luma(r_sel, g_sel, b_sel);
            c_blend_in = 1'b1;
         end
         default: begin
            c_gray_in = GRAY_UNKNOWN;
         end
      endcase
   end

   logic       c_valid_ff, c_last_ff, c_blend_ff;
   logic [7:0] c_gray_ff, c_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_last_ff  <= b_last_ff;
         c_blend_ff <= c_blend_in;
         c_gray_ff  <= c_gray_in;
         c_alpha_ff <= c_alpha_in;
      end
   end

   // Stage D: blend onto white when alpha applies, into the result register.
   logic       rsp_valid_ff, rsp_last_ff;
   logic [7:0] rsp_gray_ff, rsp_gray_in;

   assign rsp_gray_in = c_blend_ff ? over_white(c_gray_ff, c_alpha_ff) : c_gray_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_gray_ff <= rsp_gray_in;
         rsp_last_ff <= c_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_gray_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire
